/* rtl/bpa_pkg.sv */
// shared types and constants for the buddy page allocator
// no dependencies
package bpa_pkg;

    localparam int FRAME_W         = 20;
    localparam int ORDER_W         = 4;
    localparam int STATUS_W        = 2;
    localparam int REGION_W        = 9;
    localparam int LVL_W           = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int TOP_ORDER_DEF   = 4;
    localparam int NUM_PAGES_DEF   = 4096;
    localparam int REGION_RESET    = 256;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ORD  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_REGION = 1'b1;

    typedef enum logic [1:0] {
        CMD_BAD,
        CMD_NOP,
        CMD_ALLOC,
        CMD_FREE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [ORDER_W-1:0]   ord;
        logic [FRAME_W-1:0]   page;
    } cmd_t;

endpackage

/* rtl/bpa_front.sv */
// front end: takes input words, checks order, range and alignment
// depends on bpa_pkg
module bpa_front
    import bpa_pkg::*;
#(
    parameter int TOP_ORDER = TOP_ORDER_DEF,
    parameter int AW        = 13
)
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [ORDER_W-1:0] order,
    input  logic [FRAME_W-1:0] frame,
    input  logic [FRAME_W-1:0] base_frame,
    input  logic [AW-1:0]      managed,
    input  logic               q_full,
    input  logic               clearing,
    output logic               push,
    output cmd_t               cmd
);

    logic [FRAME_W-1:0] page;
    logic               misaligned;
    logic               outside;

    assign page       = frame - base_frame;
    assign misaligned = (page & ~({FRAME_W{1'b1}} << order)) != '0;
    assign outside    = 32'(page) >= 32'(managed);

    assign in_stall = q_full | clearing;
    assign push     = in_valid & ~in_stall;

    always_comb
    begin
        cmd.ord  = order;
        cmd.page = page;
        if (32'(order) > TOP_ORDER)
            cmd.kind = CMD_BAD;
        else if (opcode == OP_ALLOC)
            cmd.kind = CMD_ALLOC;
        else if (outside || misaligned)
            cmd.kind = CMD_NOP;
        else
            cmd.kind = CMD_FREE;
    end

endmodule

/* rtl/bpa_queue.sv */
// short command queue between front and back
// depends on bpa_pkg
module bpa_queue
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    output logic valid,
    input  logic pop,
    output cmd_t cmd_out
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = count_reg == CW'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* rtl/bpa_back.sv */
// back end: list memory, search, split, merge and the clearing pass
// depends on bpa_pkg
module bpa_back
    import bpa_pkg::*;
#(
    parameter int TOP_ORDER = TOP_ORDER_DEF,
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int AW        = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rebuild,
    input  logic [FRAME_W-1:0]  base_frame,
    input  logic [AW-1:0]       managed,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  alloc_frame
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int HW  = $clog2(TOP_ORDER + 1);
    localparam int BLK = 1 << TOP_ORDER;
    localparam logic [AW-1:0] NIL = AW'(NUM_PAGES);

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic             free;
        logic [AW-1:0]    nxt;
        logic [AW-1:0]    prv;
    } page_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6,
        S_A0, S_A1, S_SPLIT,
        S_P0, S_P1, S_P2,
        S_F0, S_F1, S_MERGE, S_M1, S_M2,
        S_DONE
    } state_t;

    page_t mem [NUM_PAGES];
    page_t rdata_reg;

    state_t               state_reg;
    state_t               ret_u_reg;
    state_t               ret_p_reg;
    logic [AW-1:0]        head_reg [TOP_ORDER+1];
    logic [AW-1:0]        clr_cnt_reg;
    logic [AW-1:0]        x_reg;
    logic [AW-1:0]        up_reg;
    logic [AW-1:0]        un_reg;
    logic [AW-1:0]        pb_reg;
    logic [LVL_W-1:0]     pl_reg;
    logic [AW-1:0]        ph_reg;
    logic [AW-1:0]        pg_reg;
    logic [AW-1:0]        bd_reg;
    logic [LVL_W-1:0]     cur_reg;
    logic [LVL_W-1:0]     ord_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [FRAME_W-1:0]   res_frame_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [FRAME_W-1:0]   alloc_frame_reg;

    logic            mem_we;
    logic [PW-1:0]   mem_waddr;
    page_t           mem_wdata;
    logic            mem_re;
    logic [PW-1:0]   mem_raddr;

    // clearing pass word for one page
    page_t           init_word;
    logic            init_head;
    logic [AW-1:0]   init_up;

    // allocate search over the list heads
    logic             found;
    logic [LVL_W-1:0] found_lvl;

    // split and merge helpers
    logic [LVL_W-1:0] cur_dec;
    logic [AW:0]      split_b;
    logic [AW-1:0]    merge_b;

    assign clearing    = state_reg == S_CLEAR;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign alloc_frame = alloc_frame_reg;
    assign q_pop       = (state_reg == S_IDLE) && q_valid;

    assign init_up   = clr_cnt_reg + AW'(BLK);
    assign init_head = (clr_cnt_reg < managed) && (clr_cnt_reg[TOP_ORDER-1:0] == '0);
    always_comb
    begin
        init_word.lvl  = init_head ? LVL_W'(TOP_ORDER) : '0;
        init_word.free = init_head;
        init_word.nxt  = (init_head && clr_cnt_reg >= AW'(BLK)) ? clr_cnt_reg - AW'(BLK) : NIL;
        init_word.prv  = (init_head && init_up < managed) ? init_up : NIL;
    end

    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int c = 0; c <= TOP_ORDER; c++)
        begin
            if (!found && c >= 32'(q_cmd.ord) && head_reg[c] != NIL)
            begin
                found     = 1'b1;
                found_lvl = LVL_W'(c);
            end
        end
    end

    assign cur_dec = cur_reg - 1'b1;
    assign split_b = {1'b0, x_reg} + ((AW+1)'(1) << cur_dec);
    assign merge_b = pg_reg ^ (AW'(1) << cur_reg);

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[PW-1:0];
                mem_wdata = init_word;
            end
            S_U0, S_U5, S_A0:
            begin
                mem_re    = 1'b1;
                mem_raddr = x_reg[PW-1:0];
            end
            S_U1:
            begin
                mem_re    = rdata_reg.prv != NIL;
                mem_raddr = rdata_reg.prv[PW-1:0];
            end
            S_U2:
            begin
                mem_we        = 1'b1;
                mem_waddr     = up_reg[PW-1:0];
                mem_wdata.nxt = un_reg;
            end
            S_U3:
            begin
                mem_re    = un_reg != NIL;
                mem_raddr = un_reg[PW-1:0];
            end
            S_U4:
            begin
                mem_we        = 1'b1;
                mem_waddr     = un_reg[PW-1:0];
                mem_wdata.prv = up_reg;
            end
            S_U6:
            begin
                mem_we         = 1'b1;
                mem_waddr      = x_reg[PW-1:0];
                mem_wdata.nxt  = NIL;
                mem_wdata.prv  = NIL;
                mem_wdata.free = 1'b0;
            end
            S_A1:
            begin
                mem_we        = 1'b1;
                mem_waddr     = x_reg[PW-1:0];
                mem_wdata.lvl = ord_reg;
            end
            S_P0:
            begin
                mem_we         = 1'b1;
                mem_waddr      = pb_reg[PW-1:0];
                mem_wdata.lvl  = pl_reg;
                mem_wdata.free = 1'b1;
                mem_wdata.nxt  = head_reg[pl_reg[HW-1:0]];
                mem_wdata.prv  = NIL;
            end
            S_P1:
            begin
                mem_re    = 1'b1;
                mem_raddr = ph_reg[PW-1:0];
            end
            S_P2:
            begin
                mem_we        = 1'b1;
                mem_waddr     = ph_reg[PW-1:0];
                mem_wdata.prv = pb_reg;
            end
            S_F0:
            begin
                mem_re    = 1'b1;
                mem_raddr = pg_reg[PW-1:0];
            end
            S_MERGE:
            begin
                mem_re    = (32'(cur_reg) < TOP_ORDER) && (merge_b < NIL);
                mem_raddr = merge_b[PW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_u_reg     <= S_IDLE;
            ret_p_reg     <= S_IDLE;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= TOP_ORDER; i++)
                head_reg[i] <= NIL;
        end
        else
        begin
            // the done state reloads the output word itself
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            if (rebuild)
            begin
                state_reg   <= S_CLEAR;
                clr_cnt_reg <= '0;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                        if (clr_cnt_reg == NIL - 1'b1)
                        begin
                            for (int i = 0; i < TOP_ORDER; i++)
                                head_reg[i] <= NIL;
                            head_reg[TOP_ORDER] <= (managed != '0) ? managed - AW'(BLK) : NIL;
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (q_valid)
                        begin
                            res_status_reg <= ST_OK;
                            res_frame_reg  <= '0;
                            ord_reg        <= q_cmd.ord;
                            case (q_cmd.kind)
                                CMD_BAD:
                                begin
                                    res_status_reg <= ST_BAD_ORD;
                                    state_reg      <= S_DONE;
                                end
                                CMD_ALLOC:
                                begin
                                    if (found)
                                    begin
                                        x_reg     <= head_reg[found_lvl[HW-1:0]];
                                        cur_reg   <= found_lvl;
                                        ret_u_reg <= S_A0;
                                        state_reg <= S_U0;
                                    end
                                    else
                                    begin
                                        res_status_reg <= ST_NO_BLOCK;
                                        state_reg      <= S_DONE;
                                    end
                                end
                                CMD_FREE:
                                begin
                                    pg_reg    <= q_cmd.page[AW-1:0];
                                    x_reg     <= q_cmd.page[AW-1:0];
                                    cur_reg   <= q_cmd.ord;
                                    state_reg <= S_F0;
                                end
                                default:
                                    state_reg <= S_DONE;
                            endcase
                        end
                    end
                    // unlink of x_reg
                    S_U0:
                        state_reg <= S_U1;
                    S_U1:
                    begin
                        up_reg <= rdata_reg.prv;
                        un_reg <= rdata_reg.nxt;
                        if (rdata_reg.prv != NIL)
                            state_reg <= S_U2;
                        else
                        begin
                            if (32'(rdata_reg.lvl) <= TOP_ORDER
                                && head_reg[rdata_reg.lvl[HW-1:0]] == x_reg)
                                head_reg[rdata_reg.lvl[HW-1:0]] <= rdata_reg.nxt;
                            state_reg <= S_U3;
                        end
                    end
                    S_U2:
                        state_reg <= S_U3;
                    S_U3:
                        state_reg <= (un_reg != NIL) ? S_U4 : S_U5;
                    S_U4:
                        state_reg <= S_U5;
                    S_U5:
                        state_reg <= S_U6;
                    S_U6:
                        state_reg <= ret_u_reg;
                    // allocate: retag the page, then split down
                    S_A0:
                        state_reg <= S_A1;
                    S_A1:
                        state_reg <= S_SPLIT;
                    S_SPLIT:
                    begin
                        if (cur_reg > ord_reg)
                        begin
                            cur_reg <= cur_dec;
                            if (split_b < {1'b0, NIL})
                            begin
                                pb_reg    <= split_b[AW-1:0];
                                pl_reg    <= cur_dec;
                                ret_p_reg <= S_SPLIT;
                                state_reg <= S_P0;
                            end
                        end
                        else
                        begin
                            res_frame_reg <= base_frame + FRAME_W'(x_reg);
                            state_reg     <= S_DONE;
                        end
                    end
                    // push pb_reg onto list pl_reg
                    S_P0:
                    begin
                        ph_reg <= head_reg[pl_reg[HW-1:0]];
                        head_reg[pl_reg[HW-1:0]] <= pb_reg;
                        state_reg <= (head_reg[pl_reg[HW-1:0]] != NIL) ? S_P1 : ret_p_reg;
                    end
                    S_P1:
                        state_reg <= S_P2;
                    S_P2:
                        state_reg <= ret_p_reg;
                    // free: drop a stale free head, then merge upward
                    S_F0:
                        state_reg <= S_F1;
                    S_F1:
                    begin
                        if (rdata_reg.free)
                        begin
                            ret_u_reg <= S_MERGE;
                            state_reg <= S_U0;
                        end
                        else
                            state_reg <= S_MERGE;
                    end
                    S_MERGE:
                    begin
                        if ((32'(cur_reg) < TOP_ORDER) && (merge_b < NIL))
                        begin
                            bd_reg    <= merge_b;
                            state_reg <= S_M1;
                        end
                        else
                        begin
                            pb_reg    <= pg_reg;
                            pl_reg    <= cur_reg;
                            ret_p_reg <= S_DONE;
                            state_reg <= S_P0;
                        end
                    end
                    S_M1:
                    begin
                        if (rdata_reg.free && rdata_reg.lvl == cur_reg)
                        begin
                            x_reg     <= bd_reg;
                            ret_u_reg <= S_M2;
                            state_reg <= S_U0;
                        end
                        else
                        begin
                            pb_reg    <= pg_reg;
                            pl_reg    <= cur_reg;
                            ret_p_reg <= S_DONE;
                            state_reg <= S_P0;
                        end
                    end
                    S_M2:
                    begin
                        pg_reg    <= pg_reg & bd_reg;
                        cur_reg   <= cur_reg + 1'b1;
                        state_reg <= S_MERGE;
                    end
                    S_DONE:
                    begin
                        if (!out_valid_reg || !out_stall)
                        begin
                            out_valid_reg   <= 1'b1;
                            status_reg      <= res_status_reg;
                            alloc_frame_reg <= res_frame_reg;
                            state_reg       <= S_IDLE;
                        end
                    end
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule

/* rtl/buddy_page_allocator.sv */
// top level of the buddy page allocator: configuration registers and wiring
// depends on bpa_pkg, bpa_front, bpa_queue and bpa_back
//
// Binary buddy page allocator over NUM_PAGES pages grouped into top-order
// blocks of 2^TOP_ORDER pages. An allocate word (opcode 0) returns the frame
// of a block of the given order, taken from the lowest non-empty free list at
// or above it and split down; a free word (opcode 1) merges the block with
// free buddies of the same level and returns it. Orders above TOP_ORDER give
// status bad order. The front end checks and queues words; the back end runs
// a sequencer over one page memory (level, free mark and list links per page)
// with one read and one write per cycle, read data registered. Each list
// update is a read-modify-write through the page memory. A bad order, an
// ignored free or a failed allocate goes straight to the result; an
// allocate otherwise unlinks a block and splits it down step by step, and
// a free merges upward step by step. After reset and after every write of
// the region register a clearing pass over all NUM_PAGES pages rebuilds
// the lists; no word is taken during it, configuration writes still are.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int TOP_ORDER = TOP_ORDER_DEF,
    parameter int NUM_PAGES = NUM_PAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // input words
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [ORDER_W-1:0]  order,
    input  logic [FRAME_W-1:0]  frame,
    // result words
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  alloc_frame,
    // configuration writes
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [FRAME_W-1:0]  wr_data
);

    // page index width with room for the list end marker
    localparam int AW  = $clog2(NUM_PAGES) + 1;
    localparam int CAP = NUM_PAGES >> TOP_ORDER;

    logic [FRAME_W-1:0]  base_frame_reg;
    logic [REGION_W-1:0] region_reg;
    logic [AW-1:0]       managed;
    logic                rebuild;

    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    cmd_t front_cmd;
    cmd_t q_cmd;
    logic clearing;

    // managed pages: region clamped to storage, in whole top blocks
    assign managed = (32'(region_reg) > CAP) ? AW'(CAP << TOP_ORDER)
                                             : AW'(32'(region_reg) << TOP_ORDER);

    assign rebuild = wr_en && (wr_index == REG_REGION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_frame_reg <= '0;
            region_reg     <= REGION_W'(REGION_RESET);
        end
        else if (wr_en)
        begin
            if (wr_index == REG_BASE)
                base_frame_reg <= wr_data;
            else
                region_reg <= wr_data[REGION_W-1:0];
        end
    end

    bpa_front #(
        .TOP_ORDER (TOP_ORDER),
        .AW        (AW)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .order      (order),
        .frame      (frame),
        .base_frame (base_frame_reg),
        .managed    (managed),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (q_push),
        .cmd        (front_cmd)
    );

    bpa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .cmd_out (q_cmd)
    );

    bpa_back #(
        .TOP_ORDER (TOP_ORDER),
        .NUM_PAGES (NUM_PAGES),
        .AW        (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rebuild     (rebuild),
        .base_frame  (base_frame_reg),
        .managed     (managed),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .alloc_frame (alloc_frame)
    );

endmodule
